// ===== sv/affine_point_transform_assert.svh =====
// Assertion macros shared by the affine point transform RTL.
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define APT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define APT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/apt_pkg.sv =====
// Shared constants for the affine point transform.
`timescale 1ns / 1ps
package apt_pkg;

  // Default datapath parameters.
  localparam int DEF_COORD_WIDTH    = 32;
  localparam int DEF_COEF_FRAC_BITS = 24;

  // Field widths of the configuration registers.
  localparam int COEF_W = 32;
  localparam int OFFS_W = 32;
  localparam int REG_W  = 64;

  // Register file geometry: register i sits at byte address 8*i.
  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = 6;
  localparam int IDX_W    = 3;
  localparam int IDX_LSB  = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_ROW0_XY = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_ZT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_XY = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_ZT = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_XY = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_ZT = 3'd5;

  // Pipeline depth from input register to output register.
  localparam int NUM_STAGES = 5;

endpackage

// ===== sv/affine_point_transform.sv =====
// Top level of the affine point transform: config registers and pipelined datapath.
`timescale 1ns / 1ps
`include "affine_point_transform_assert.svh"

// Applies a 3x4 affine matrix to a stream of signed fixed point 3D points. The
// datapath is a five stage pipeline (split multiplies, product merge, row sum with
// rounding, shift and translation, saturation) that accepts one point in every
// cycle while the output is not stalled. Each point passes through the s1, s2, s3
// and s4 registers into the output register, and results leave in order. Every
// stage holds its own valid bit, so a stalled output still lets new points fill the
// empty stages behind it. The six 64-bit matrix registers sit at byte addresses
// 0, 8, ..., 40 of the APB port, reset to the identity matrix, and must only be
// written while no point is in flight.
module affine_point_transform #(
  parameter int COORD_WIDTH    = apt_pkg::DEF_COORD_WIDTH,
  parameter int COEF_FRAC_BITS = apt_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Point input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          saturated,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apt_pkg::ADDR_W-1:0]    paddr,
  input  logic [apt_pkg::REG_W-1:0]     pwdata,
  output logic [apt_pkg::REG_W-1:0]     prdata,
  output logic                          pready
);
  import apt_pkg::*;

  // Datapath widths.
  localparam int LO_W   = COORD_WIDTH / 2;
  localparam int HI_W   = COORD_WIDTH - LO_W;
  localparam int HI_P_W = HI_W + COEF_W;
  localparam int LO_P_W = LO_W + COEF_W + 1;
  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int SH_W   = SUM_W - COEF_FRAC_BITS;
  localparam int RES_W  = ((SH_W > OFFS_W) ? SH_W : OFFS_W) + 1;

  // Fixed point 1.0 for the coefficients and the rounding constant.
  localparam logic [COEF_W-1:0] COEF_ONE =
    {{(COEF_W-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    {{(SUM_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  // Saturation bounds.
  localparam logic signed [RES_W-1:0] RES_MAX =
    {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] cfg [NUM_REGS];
  logic [IDX_W-1:0] cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite;

  // Registers load on the access cycle of a write; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_ROW0_XY] <= {{COEF_W{1'b0}}, COEF_ONE};
      cfg[REG_ROW0_ZT] <= '0;
      cfg[REG_ROW1_XY] <= {COEF_ONE, {COEF_W{1'b0}}};
      cfg[REG_ROW1_ZT] <= '0;
      cfg[REG_ROW2_XY] <= '0;
      cfg[REG_ROW2_ZT] <= {{OFFS_W{1'b0}}, COEF_ONE};
    end else if (cfg_wr && (cfg_idx < IDX_W'(NUM_REGS))) begin
      cfg[cfg_idx] <= pwdata;
    end
  end

  // Read data for the addressed register.
  always_comb begin
    prdata = '0;
    if (cfg_idx < IDX_W'(NUM_REGS)) begin
      prdata = cfg[cfg_idx];
    end
  end

  // Coefficients per row and column, and the translation per row.
  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [OFFS_W-1:0] offs [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = cfg[2*r][COEF_W-1:0];
      coef[r][1] = cfg[2*r][REG_W-1:COEF_W];
      coef[r][2] = cfg[2*r+1][COEF_W-1:0];
      offs[r]    = cfg[2*r+1][REG_W-1:COEF_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] rdy;

  // A stage takes a new request when it is empty or its contents move on.
  always_comb begin
    rdy[NUM_STAGES-1] = !v[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: each coordinate split in halves, each half times a coefficient
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [HI_W-1:0]        pt_hi [3];
  logic signed [LO_W:0]          pt_lo [3];
  logic signed [HI_P_W-1:0]      mul_hi [3][3];
  logic signed [LO_P_W-1:0]      mul_lo [3][3];
  logic signed [HI_P_W-1:0]      s1_hi [3][3];
  logic signed [LO_P_W-1:0]      s1_lo [3][3];

  assign pt[0] = in_x;
  assign pt[1] = in_y;
  assign pt[2] = in_z;

  // The low half is taken as unsigned, the high half carries the sign.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_hi[k] = pt[k][COORD_WIDTH-1:LO_W];
      pt_lo[k] = {1'b0, pt[k][LO_W-1:0]};
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        mul_hi[r][k] = pt_hi[k] * coef[r][k];
        mul_lo[r][k] = pt_lo[k] * coef[r][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_hi <= mul_hi;
      s1_lo <= mul_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: merge the two partial products of each term
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [PROD_W-1:0] s2_prod [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] = $signed({s1_hi[r][k], {LO_W{1'b0}}}) +
                     $signed({{(PROD_W-LO_P_W){s1_lo[r][k][LO_P_W-1]}}, s1_lo[r][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_prod <= prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: row sum of the three terms plus one half for rounding
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] row_sum [3];
  logic signed [SUM_W-1:0] s3_sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = $signed({{(SUM_W-PROD_W){s2_prod[r][0][PROD_W-1]}}, s2_prod[r][0]}) +
                   $signed({{(SUM_W-PROD_W){s2_prod[r][1][PROD_W-1]}}, s2_prod[r][1]}) +
                   $signed({{(SUM_W-PROD_W){s2_prod[r][2][PROD_W-1]}}, s2_prod[r][2]}) +
                   ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sum <= row_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: drop the fraction bits (floor) and add the translation
  // ---------------------------------------------------------------------------
  logic signed [SH_W-1:0]  row_sh [3];
  logic signed [RES_W-1:0] row_res [3];
  logic signed [RES_W-1:0] s4_res [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sh[r]  = s3_sum[r][SUM_W-1:COEF_FRAC_BITS];
      row_res[r] = $signed({{(RES_W-SH_W){row_sh[r][SH_W-1]}}, row_sh[r]}) +
                   $signed({{(RES_W-OFFS_W){offs[r][OFFS_W-1]}}, offs[r]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_res <= row_res;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: clip each coordinate to the output range; this is the output register
  // ---------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] coord_next [3];
  logic                   clip_next;
  logic [COORD_WIDTH-1:0] coord [3];

  always_comb begin
    clip_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (s4_res[r] > RES_MAX) begin
        coord_next[r] = COORD_MAX;
        clip_next     = 1'b1;
      end else if (s4_res[r] < RES_MIN) begin
        coord_next[r] = COORD_MIN;
        clip_next     = 1'b1;
      end else begin
        coord_next[r] = s4_res[r][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      coord     <= coord_next;
      saturated <= clip_next;
    end
  end

  assign out_x = coord[0];
  assign out_y = coord[1];
  assign out_z = coord[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `APT_ASSERT(a_sat_at_bound,
    out_valid && saturated |->
      (out_x == COORD_MAX || out_x == COORD_MIN || out_y == COORD_MAX ||
       out_y == COORD_MIN || out_z == COORD_MAX || out_z == COORD_MIN),
    "saturated flag set but no coordinate sits at a bound")
  `APT_ASSERT(a_accept_fills_stage,
    in_valid && in_ready |=> v[0],
    "accepted request did not enter the first stage")
  `APT_ASSERT(a_full_stall,
    (&v) && !out_ready |-> !in_ready,
    "input accepted while every stage is full and stalled")
  `APT_ASSERT(a_cfg_write,
    cfg_wr && (cfg_idx < IDX_W'(NUM_REGS)) |=> cfg[$past(cfg_idx)] == $past(pwdata),
    "configuration write did not reach its register")
  `APT_ASSERT_RST(a_reset_empty,
    rst |=> (v == '0),
    "pipeline holds valid data after reset")

endmodule

// ===== dv/affine_point_transform_checker.sv =====
// Checker for the affine point transform: tracks the matrix, predicts each result, compares.
`timescale 1ns / 1ps
module affine_point_transform_checker #(
  parameter int CW   = apt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC = apt_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [CW-1:0]          in_x,
  input  logic signed [CW-1:0]          in_y,
  input  logic signed [CW-1:0]          in_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [CW-1:0]          out_x,
  input  logic signed [CW-1:0]          out_y,
  input  logic signed [CW-1:0]          out_z,
  input  logic                          saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [apt_pkg::ADDR_W-1:0]    paddr,
  input  logic [apt_pkg::REG_W-1:0]     pwdata,
  input  logic [apt_pkg::REG_W-1:0]     prdata,
  output int                            fail_count,
  output int                            outstanding
);
  import apt_pkg::*;

  // Wide enough to hold three full products, the rounding term and the offset.
  localparam int ACC_W = CW + 40;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] COORD_MAX  = (ACC_W'(1) << (CW - 1)) - 1;
  localparam logic signed [ACC_W-1:0] COORD_MIN  = -COORD_MAX - 1;
  localparam logic [REG_W-1:0]        UNIT_COEF  = REG_W'(1) << FRAC;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 sat;
  } point_t;

  logic [REG_W-1:0] matrix [NUM_REGS];
  point_t           pending_points [$];
  int               mismatches = 0;

  // Transforms one point with the current matrix, rounding and saturating each row.
  function automatic point_t transform_point(input logic signed [CW-1:0] px,
                                             input logic signed [CW-1:0] py,
                                             input logic signed [CW-1:0] pz);
    logic signed [ACC_W-1:0] ex, ey, ez, cx, cy, cz, offs, acc;
    logic [REG_W-1:0]        xy, zt;
    point_t                  res;
    ex = px;
    ey = py;
    ez = pz;
    res = '0;
    for (int r = 0; r < 3; r++) begin
      xy   = matrix[2*r];
      zt   = matrix[2*r+1];
      cx   = $signed(xy[COEF_W-1:0]);
      cy   = $signed(xy[REG_W-1:COEF_W]);
      cz   = $signed(zt[COEF_W-1:0]);
      offs = $signed(zt[REG_W-1:COEF_W]);
      acc  = ex * cx + ey * cy + ez * cz + ROUND_HALF;
      acc  = acc >>> FRAC;
      acc  = acc + offs;
      if (acc > COORD_MAX) begin
        acc     = COORD_MAX;
        res.sat = 1'b1;
      end else if (acc < COORD_MIN) begin
        acc     = COORD_MIN;
        res.sat = 1'b1;
      end
      case (r)
        0: res.x = acc[CW-1:0];
        1: res.y = acc[CW-1:0];
        default: res.z = acc[CW-1:0];
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [REG_W-1:0] want,
                                 input logic [REG_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Follow register traffic and both request channels on every edge.
  always @(posedge clk) begin : watch
    int     idx;
    point_t got, want;
    if (rst) begin
      foreach (matrix[i]) matrix[i] = '0;
      matrix[REG_ROW0_XY] = UNIT_COEF;
      matrix[REG_ROW1_XY] = UNIT_COEF << COEF_W;
      matrix[REG_ROW2_ZT] = UNIT_COEF;
      pending_points.delete();
    end else begin
      // Register writes and reads complete in the access phase.
      if (psel && penable && pready) begin
        idx = int'(paddr >> IDX_LSB);
        if (pwrite) begin
          if (idx < NUM_REGS) matrix[idx] = pwdata;
        end else if (idx < NUM_REGS && prdata !== matrix[idx]) begin
          report_mismatch($sformatf("read of register %0d", idx), matrix[idx], prdata);
        end
      end
      // Results are checked before new requests are queued.
      if (out_valid && out_ready) begin
        got.x   = out_x;
        got.y   = out_y;
        got.z   = out_z;
        got.sat = saturated;
        if (pending_points.size() == 0) begin
          report_mismatch("result with no request pending", '0, REG_W'(got.x));
        end else begin
          want = pending_points.pop_front();
          if (got.x !== want.x) report_mismatch("out_x", REG_W'(want.x), REG_W'(got.x));
          if (got.y !== want.y) report_mismatch("out_y", REG_W'(want.y), REG_W'(got.y));
          if (got.z !== want.z) report_mismatch("out_z", REG_W'(want.z), REG_W'(got.z));
          if (got.sat !== want.sat)
            report_mismatch("saturated", REG_W'(want.sat), REG_W'(got.sat));
        end
      end
      if (in_valid && in_ready)
        pending_points.push_back(transform_point(in_x, in_y, in_z));
    end
    fail_count  <= mismatches;
    outstanding <= pending_points.size();
  end

endmodule

// ===== dv/tb_affine_point_transform.sv =====
// Testbench top for the affine point transform: stimulus, pacing and the final verdict.
`timescale 1ns / 1ps
module tb_affine_point_transform;
  import apt_pkg::*;

  localparam int               CW          = DEF_COORD_WIDTH;
  localparam int               NUM_PHASES  = 8;
  localparam int               PHASE_ITEMS = 200;
  localparam int               LONG_HOLD   = 300;
  localparam int               STALL_LIMIT = 4000;
  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << DEF_COEF_FRAC_BITS;
  localparam logic [COEF_W-1:0] COEF_HALF  = COEF_ONE >> 1;
  localparam logic [COEF_W-1:0] WORD_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] WORD_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [CW-1:0] PT_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] PT_MIN  = {1'b1, {(CW-1){1'b0}}};

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic                 saturated;
  logic                 psel, penable, pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [REG_W-1:0]     pwdata;
  logic [REG_W-1:0]     prdata;
  logic                 pready;
  int                   checker_fails;
  int                   checker_pending;
  int                   stall_cycles = 0;
  bit                   calm = 1'b0;
  bit                   hold_request = 1'b0;

  affine_point_transform u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  affine_point_transform_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .saturated   (saturated),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .fail_count  (checker_fails),
    .outstanding (checker_pending)
  );

  // Free running clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random ready bursts, one long hold-off on request, steady when calm.
  initial begin : receiver
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        if ($urandom_range(0, 1) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end
  end

  // Random word sign-extended from a random width of at most max_w bits.
  function automatic logic [31:0] rand_word(input int max_w);
    int unsigned sh;
    logic [31:0] v;
    sh = 32 - $urandom_range(1, max_w);
    v  = $urandom;
    return $signed(v << sh) >>> sh;
  endfunction

  task automatic reg_write(input int idx, input logic [REG_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << IDX_LSB);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input int idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx << IDX_LSB);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_matrix();
    for (int i = 0; i < NUM_REGS; i++) reg_read(i);
  endtask

  // Same coefficient in every slot, same offset on every row.
  task automatic load_uniform(input logic [COEF_W-1:0] coef, input logic [OFFS_W-1:0] offs);
    for (int r = 0; r < 3; r++) begin
      reg_write(int'(REG_ROW0_XY) + 2 * r, {coef, coef});
      reg_write(int'(REG_ROW0_ZT) + 2 * r, {offs, coef});
    end
    read_matrix();
  endtask

  task automatic load_random_matrix();
    logic [COEF_W-1:0] c0, c1;
    for (int i = 0; i < NUM_REGS; i++) begin
      c0 = rand_word(($urandom_range(0, 3) == 0) ? 32 : 26);
      c1 = rand_word(($urandom_range(0, 3) == 0) ? 32 : 26);
      reg_write(i, {c1, c0});
    end
    if ($urandom_range(0, 1) == 0)
      reg_write(NUM_REGS + $urandom_range(0, 1), {$urandom, $urandom});
    read_matrix();
  endtask

  // Offers one request, with an optional gap first, and waits for it to be taken.
  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every pending result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (checker_pending != 0);
  endtask

  initial begin : stimulus
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_x     <= '0;
    in_y     <= '0;
    in_z     <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix out of reset.
    read_matrix();
    send_point('0, '0, '0);
    send_point(PT_MAX, PT_MAX, PT_MAX);
    send_point(PT_MIN, PT_MIN, PT_MIN);
    send_point(1, -1, PT_MAX);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh1234_5678);
    wait_drain();

    // Largest coefficients and offset: overflow upward and downward.
    load_uniform(WORD_MAX, WORD_MAX);
    send_point(PT_MAX, PT_MAX, PT_MAX);
    send_point(PT_MIN, PT_MIN, PT_MIN);
    send_point('0, '0, '0);
    wait_drain();
    // Writes past the last register must leave the matrix alone.
    reg_write(NUM_REGS, '0);
    reg_write(NUM_REGS + 1, '0);
    read_matrix();
    send_point(1, 1, 1);
    wait_drain();

    // Most negative coefficients and offset.
    load_uniform(WORD_MIN, WORD_MIN);
    send_point(PT_MIN, PT_MIN, PT_MIN);
    send_point(PT_MAX, '0, '0);
    send_point('0, '0, '0);
    send_point(-1, '0, '0);
    wait_drain();

    // Halves that land exactly between two outputs round toward plus infinity.
    reg_write(int'(REG_ROW0_XY), {COEF_HALF, COEF_HALF});
    reg_write(int'(REG_ROW0_ZT), '0);
    reg_write(int'(REG_ROW1_XY), {{COEF_W{1'b0}}, -COEF_HALF});
    reg_write(int'(REG_ROW1_ZT), '0);
    reg_write(int'(REG_ROW2_XY), {{COEF_W{1'b0}}, COEF_ONE + COEF_HALF});
    reg_write(int'(REG_ROW2_ZT), '0);
    read_matrix();
    send_point(1, '0, '0);
    send_point(-1, '0, '0);
    send_point(3, 5, 7);
    send_point(PT_MAX, PT_MIN, '0);
    wait_drain();

    // Random phases, each with a fresh matrix.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_random_matrix();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 2 && i == 40) hold_request = 1'b1;
        if (phase == 4 && i == 100) wait_drain();
        calm = (phase == NUM_PHASES - 1) || (i >= 150);
        send_point(rand_word(32), rand_word(32), rand_word(32));
      end
      wait_drain();
    end

    // Give any stray result time to show up before the verdict.
    repeat (NUM_STAGES * 4) @(posedge clk);
    if (checker_fails == 0 && checker_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== affine_point_transform.f =====
+incdir+sv
sv/apt_pkg.sv
sv/affine_point_transform.sv
dv/affine_point_transform_checker.sv
dv/tb_affine_point_transform.sv
